@@ sv/vector_reflect_refract_unit_defines.svh @@
// Assertion macros for the vector reflect/refract unit.
// No dependencies; included by the modules that carry assertions.
`ifndef VECTOR_REFLECT_REFRACT_UNIT_DEFINES_SVH
`define VECTOR_REFLECT_REFRACT_UNIT_DEFINES_SVH

// ante implies cons in the same cycle
`define VRR_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("vrr assertion failed");

// ante implies cons in the following cycle
`define VRR_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("vrr assertion failed");

`endif

@@ sv/vrr_pkg.sv @@
// Types, constants and fixed-point helpers for the vector reflect/refract unit.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package vrr_pkg;

  localparam int CW   = 16;             // component width
  localparam int FB   = 13;             // fraction bits
  localparam int IW   = CW + 3;         // intermediate width
  localparam int PW   = 2 * IW - FB + 1; // rounded product width
  localparam int SW   = PW + 2;         // sum width
  localparam int VW   = IW - 1 + FB;    // radicand width
  localparam int RW   = (VW + 1) / 2;   // root width
  localparam int REMW = RW + 3;         // remainder width

  localparam logic signed [IW-1:0] ONE = IW'(1 << FB);

  typedef enum logic {
    ACT_REFLECT = 1'b0,
    ACT_REFRACT = 1'b1
  } action_e;

  typedef struct packed {
    action_e                action;
    logic signed [CW-1:0]   inc_x;
    logic signed [CW-1:0]   inc_y;
    logic signed [CW-1:0]   inc_z;
    logic signed [CW-1:0]   nrm_x;
    logic signed [CW-1:0]   nrm_y;
    logic signed [CW-1:0]   nrm_z;
    logic        [CW-2:0]   ratio;
  } req_t;

  typedef struct packed {
    logic signed [CW-1:0] out_x;
    logic signed [CW-1:0] out_y;
    logic signed [CW-1:0] out_z;
    logic                 total_internal;
    logic                 saturated;
  } res_t;

  // sideband that rides along the square-root stages
  typedef struct packed {
    action_e             action;
    logic [2:0][CW-1:0]  nrm;
    logic [2:0][PW-1:0]  a;     // I (reflect) or eta*I (refract)
    logic [PW-1:0]       ed;    // eta*(N.I)
    logic [IW-1:0]       s;     // 2(N.I)
    logic                tir;
    logic                sat;
  } sb_t;

  // round(a*b / 2^FB), half away from zero
  function automatic logic signed [PW-1:0] mulr(input logic signed [IW-1:0] a,
                                                input logic signed [IW-1:0] b);
    logic signed [2*IW-1:0] p;
    logic        [2*IW-1:0] mag;
    logic        [2*IW-1:0] rm;
    p   = a * b;
    mag = p[2*IW-1] ? (2*IW)'(-p) : (2*IW)'(p);
    rm  = (mag + {{(2*IW-FB){1'b0}}, 1'b1, {(FB-1){1'b0}}}) >> FB;
    return p[2*IW-1] ? -$signed(rm[PW-1:0]) : $signed(rm[PW-1:0]);
  endfunction

  function automatic logic ovf_iw(input logic signed [SW-1:0] v);
    return v[SW-1:IW-1] != {(SW-IW+1){v[IW-1]}};
  endfunction

  function automatic logic signed [IW-1:0] clip_iw(input logic signed [SW-1:0] v);
    if (!ovf_iw(v)) begin
      return v[IW-1:0];
    end
    return v[SW-1] ? {1'b1, {(IW-1){1'b0}}} : {1'b0, {(IW-1){1'b1}}};
  endfunction

  function automatic logic ovf_cw(input logic signed [SW-1:0] v);
    return v[SW-1:CW-1] != {(SW-CW+1){v[CW-1]}};
  endfunction

  function automatic logic signed [CW-1:0] clip_cw(input logic signed [SW-1:0] v);
    if (!ovf_cw(v)) begin
      return v[CW-1:0];
    end
    return v[SW-1] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
  endfunction

endpackage
`default_nettype wire

@@ sv/vrr_front.sv @@
// Front pipeline: dot product, reflect scale and refract k, six stages.
// Depends on vrr_pkg.
`timescale 1ns / 1ps
`default_nettype none
module vrr_front import vrr_pkg::*; (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          vld_i,
  input  wire req_t          req_i,
  output logic               vld_o,
  output logic [IW-2:0]      k_o,
  output sb_t                sb_o
);

  logic signed [IW-1:0] iv [3];
  logic signed [IW-1:0] nv [3];
  logic signed [IW-1:0] eta;

  assign iv[0] = IW'(req_i.inc_x);
  assign iv[1] = IW'(req_i.inc_y);
  assign iv[2] = IW'(req_i.inc_z);
  assign nv[0] = IW'(req_i.nrm_x);
  assign nv[1] = IW'(req_i.nrm_y);
  assign nv[2] = IW'(req_i.nrm_z);
  assign eta   = $signed({{(IW-CW+1){1'b0}}, req_i.ratio});

  logic [5:0] vld_q;

  // stage 1
  logic signed [PW-1:0] pin_q [3];
  logic signed [IW-1:0] e2_1_q, eta1_q;
  sb_t                  sb1_q, sb1_d;
  logic signed [PW-1:0] e2w;

  always_comb begin
    e2w           = mulr(eta, eta);
    sb1_d         = '0;
    sb1_d.action  = req_i.action;
    sb1_d.nrm[0]  = req_i.nrm_x;
    sb1_d.nrm[1]  = req_i.nrm_y;
    sb1_d.nrm[2]  = req_i.nrm_z;
    for (int i = 0; i < 3; i++) begin
      sb1_d.a[i] = (req_i.action == ACT_REFRACT) ? mulr(eta, iv[i]) : PW'(iv[i]);
    end
    sb1_d.sat = (req_i.action == ACT_REFRACT) && ovf_iw(SW'(e2w));
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      pin_q[i] <= mulr(iv[i], nv[i]);
    end
    e2_1_q <= clip_iw(SW'(e2w));
    eta1_q <= eta;
    sb1_q  <= sb1_d;
  end

  // stage 2: dot product
  logic signed [SW-1:0] dsum;
  logic signed [IW-1:0] d_q, e2_2_q, eta2_q;
  sb_t                  sb2_q, sb2_d;

  assign dsum = SW'(pin_q[0]) + SW'(pin_q[1]) + SW'(pin_q[2]);

  always_comb begin
    sb2_d     = sb1_q;
    sb2_d.sat = sb1_q.sat | ovf_iw(dsum);
  end

  always_ff @(posedge clk_i) begin
    d_q       <= clip_iw(dsum);
    e2_2_q    <= e2_1_q;
    eta2_q    <= eta1_q;
    sb2_q     <= sb2_d;
  end

  // stage 3: 2d, d^2, eta*d
  logic signed [SW-1:0] s_w, dd_w;
  logic signed [IW-1:0] dd_q, e2_3_q;
  sb_t                  sb3_q, sb3_d;
  logic                 refr2;

  assign refr2 = (sb2_q.action == ACT_REFRACT);
  assign s_w   = SW'(d_q) <<< 1;
  assign dd_w  = SW'(mulr(d_q, d_q));

  always_comb begin
    sb3_d     = sb2_q;
    sb3_d.s   = clip_iw(s_w);
    sb3_d.ed  = mulr(eta2_q, d_q);
    sb3_d.sat = sb2_q.sat | (refr2 ? ovf_iw(dd_w) : ovf_iw(s_w));
  end

  always_ff @(posedge clk_i) begin
    dd_q      <= clip_iw(dd_w);
    e2_3_q    <= e2_2_q;
    sb3_q     <= sb3_d;
  end

  // stage 4: t = 1 - d^2
  logic signed [SW-1:0] t_w;
  logic signed [IW-1:0] t_q, e2_4_q;
  sb_t                  sb4_q, sb4_d;

  assign t_w = SW'(ONE) - SW'(dd_q);

  always_comb begin
    sb4_d     = sb3_q;
    sb4_d.sat = sb3_q.sat | ((sb3_q.action == ACT_REFRACT) && ovf_iw(t_w));
  end

  always_ff @(posedge clk_i) begin
    t_q       <= clip_iw(t_w);
    e2_4_q    <= e2_3_q;
    sb4_q     <= sb4_d;
  end

  // stage 5: p = eta^2 * t
  logic signed [SW-1:0] p_w;
  logic signed [IW-1:0] p_q;
  sb_t                  sb5_q, sb5_d;

  assign p_w = SW'(mulr(e2_4_q, t_q));

  always_comb begin
    sb5_d     = sb4_q;
    sb5_d.sat = sb4_q.sat | ((sb4_q.action == ACT_REFRACT) && ovf_iw(p_w));
  end

  always_ff @(posedge clk_i) begin
    p_q       <= clip_iw(p_w);
    sb5_q     <= sb5_d;
  end

  // stage 6: k = 1 - p
  logic signed [SW-1:0] k_w;
  logic signed [IW-1:0] k_c;
  logic                 refr5, tir5;
  logic [IW-2:0]        k_q;
  sb_t                  sb6_q, sb6_d;

  assign refr5 = (sb5_q.action == ACT_REFRACT);
  assign k_w   = SW'(ONE) - SW'(p_q);
  assign k_c   = clip_iw(k_w);
  assign tir5  = refr5 && k_c[IW-1];

  always_comb begin
    sb6_d     = sb5_q;
    sb6_d.tir = tir5;
    sb6_d.sat = sb5_q.sat | (refr5 && ovf_iw(k_w));
  end

  always_ff @(posedge clk_i) begin
    k_q       <= (refr5 && !tir5) ? k_c[IW-2:0] : '0;
    sb6_q     <= sb6_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[4:0], vld_i};
    end
  end

  assign vld_o = vld_q[5];
  assign k_o   = k_q;
  assign sb_o  = sb6_q;

endmodule
`default_nettype wire

@@ sv/vrr_isqrt.sv @@
// Pipelined integer square root of k * 2^FB, one root bit per stage.
// Depends on vrr_pkg and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "vector_reflect_refract_unit_defines.svh"
module vrr_isqrt import vrr_pkg::*; (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          vld_i,
  input  wire logic [IW-2:0] k_i,
  output logic               vld_o,
  output logic [RW-1:0]      root_o
);

  logic [RW-1:0]     vld_q;
  logic [REMW-1:0]   rem_q  [RW];
  logic [RW-1:0]     root_q [RW];
  logic [2*RW-1:0]   rad_q  [RW];

  for (genvar j = 0; j < RW; j++) begin : g_stage
    logic [REMW-1:0] rem_in, remx, trial;
    logic [RW-1:0]   root_in;
    logic [2*RW-1:0] rad_in;
    logic            vin;

    if (j == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign rad_in  = (2*RW)'({k_i, {FB{1'b0}}});
      assign vin     = vld_i;
    end else begin : g_next
      assign rem_in  = rem_q[j-1];
      assign root_in = root_q[j-1];
      assign rad_in  = rad_q[j-1];
      assign vin     = vld_q[j-1];
    end

    assign remx  = {rem_in[REMW-3:0], rad_in[2*RW-1:2*RW-2]};
    assign trial = REMW'({root_in, 2'b01});

    always_ff @(posedge clk_i) begin
      if (remx >= trial) begin
        rem_q[j]  <= remx - trial;
        root_q[j] <= {root_in[RW-2:0], 1'b1};
      end else begin
        rem_q[j]  <= remx;
        root_q[j] <= {root_in[RW-2:0], 1'b0};
      end
      rad_q[j] <= rad_in << 2;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[j] <= 1'b0;
      end else begin
        vld_q[j] <= vin;
      end
    end
  end

  assign vld_o  = vld_q[RW-1];
  assign root_o = root_q[RW-1];

  // remainder never exceeds 2*root, else the root is too small
  `VRR_ASSERT_IMP(a_rem_bound, clk_i, rst_ni, vld_o, rem_q[RW-1] <= REMW'({root_q[RW-1], 1'b0}))

endmodule
`default_nettype wire

@@ sv/vrr_back.sv @@
// Back pipeline: scale factor, normal products and saturated result, three stages.
// Depends on vrr_pkg.
`timescale 1ns / 1ps
`default_nettype none
module vrr_back import vrr_pkg::*; (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          vld_i,
  input  wire logic [RW-1:0] root_i,
  input  wire sb_t           sb_i,
  output logic               done_o,
  output res_t               res_o
);

  logic [2:0] vld_q;

  // stage 7: m
  logic signed [SW-1:0] m_w;
  logic                 refr;
  logic signed [IW-1:0] m_q;
  sb_t                  sb7_q, sb7_d;

  assign refr = (sb_i.action == ACT_REFRACT);
  assign m_w  = SW'($signed(sb_i.ed)) + SW'($signed({1'b0, root_i}));

  always_comb begin
    sb7_d     = sb_i;
    sb7_d.sat = sb_i.sat | (refr && !sb_i.tir && ovf_iw(m_w));
  end

  always_ff @(posedge clk_i) begin
    m_q       <= refr ? clip_iw(m_w) : $signed(sb_i.s);
    sb7_q     <= sb7_d;
  end

  // stage 8: m * N
  logic signed [PW-1:0] q_q [3];
  sb_t                  sb8_q;

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      q_q[i] <= mulr(m_q, IW'($signed(sb7_q.nrm[i])));
    end
    sb8_q <= sb7_q;
  end

  // stage 9: a - m*N, saturate
  logic signed [SW-1:0] dif [3];
  logic signed [CW-1:0] oc  [3];
  logic                 osat;
  res_t                 res_d, res_q;

  always_comb begin
    osat = 1'b0;
    for (int i = 0; i < 3; i++) begin
      dif[i] = SW'($signed(sb8_q.a[i])) - SW'(q_q[i]);
      oc[i]  = sb8_q.tir ? '0 : clip_cw(dif[i]);
      osat   = osat | (!sb8_q.tir && ovf_cw(dif[i]));
    end
    res_d.out_x          = oc[0];
    res_d.out_y          = oc[1];
    res_d.out_z          = oc[2];
    res_d.total_internal = sb8_q.tir;
    res_d.saturated      = sb8_q.sat | osat;
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[1:0], vld_i};
    end
  end

  assign done_o = vld_q[2];
  assign res_o  = res_q;

endmodule
`default_nettype wire

@@ sv/vector_reflect_refract_unit.sv @@
// Top level of the vector reflect/refract unit.
// Depends on vrr_pkg, vrr_front, vrr_isqrt, vrr_back and the macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "vector_reflect_refract_unit_defines.svh"
// Fully pipelined: a request is taken on every cycle that start_i is high (busy_o
// stays low), and its result appears on res_o with done_o high for one cycle,
// after six front stages, sixteen square-root stages (one root bit each) and
// three back stages. Throughput is one item per cycle; the receiver
// cannot stall and results come out in request order.
module vector_reflect_refract_unit import vrr_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic start_i,
  input  wire req_t req_i,
  output logic      busy_o,
  output logic      done_o,
  output res_t      res_o
);

  logic          f_vld, q_vld;
  logic [IW-2:0] f_k;
  logic [RW-1:0] q_root;
  sb_t           f_sb;
  sb_t           sb_dly_q [RW];

  assign busy_o = 1'b0;

  vrr_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .vld_i  (start_i),
    .req_i  (req_i),
    .vld_o  (f_vld),
    .k_o    (f_k),
    .sb_o   (f_sb)
  );

  vrr_isqrt u_isqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .vld_i  (f_vld),
    .k_i    (f_k),
    .vld_o  (q_vld),
    .root_o (q_root)
  );

  always_ff @(posedge clk_i) begin
    sb_dly_q[0] <= f_sb;
    for (int i = 1; i < RW; i++) begin
      sb_dly_q[i] <= sb_dly_q[i-1];
    end
  end

  vrr_back u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .vld_i  (q_vld),
    .root_i (q_root),
    .sb_i   (sb_dly_q[RW-1]),
    .done_o (done_o),
    .res_o  (res_o)
  );

  `VRR_ASSERT_IMP(a_tir_zero, clk_i, rst_ni, done_o && res_o.total_internal, res_o.out_x == '0 && res_o.out_y == '0 && res_o.out_z == '0)
  `VRR_ASSERT_IMP(a_tir_refract, clk_i, rst_ni, f_vld && f_sb.tir, f_sb.action == ACT_REFRACT)
  `VRR_ASSERT_IMP(a_tir_k_zero, clk_i, rst_ni, f_vld && f_sb.tir, f_k == '0)

endmodule
`default_nettype wire

@@ tb/tb_vector_reflect_refract_unit.sv @@
// Testbench for vector_reflect_refract_unit: directed table, then random requests,
// each checked field by field against a listed value or a behavioral reflect/refract predictor.
// Depends on vrr_pkg and the vector_reflect_refract_unit RTL.
`timescale 1ns / 1ps
module tb_vector_reflect_refract_unit;
  import vrr_pkg::*;

  localparam int NRAND = 600;
  localparam int TAIL  = 40;

  typedef struct {
    req_t req;
    logic known;
    res_t res;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start_i = 1'b0;
  req_t req_i = '0;
  logic busy_o, done_o;
  res_t res_o;

  res_t expq[$];
  int   errors = 0;
  row_t rows[$];

  vector_reflect_refract_unit u_dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start_i(start_i), .req_i(req_i),
    .busy_o(busy_o), .done_o(done_o), .res_o(res_o)
  );

  always #1 clk_i = ~clk_i;

  function automatic longint sat_to(input longint v, input int w, inout logic f);
    longint hi, lo;
    hi = (longint'(1) << (w - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) begin f = 1'b1; return hi; end
    if (v < lo) begin f = 1'b1; return lo; end
    return v;
  endfunction

  function automatic longint rmul(input longint a, input longint b);
    longint p, m;
    p = a * b;
    m = ((p < 0 ? -p : p) + (longint'(1) << (FB - 1))) >>> FB;
    return p < 0 ? -m : m;
  endfunction

  function automatic longint int_sqrt(input longint v);
    longint r;
    r = 0;
    for (int b = 31; b >= 0; b--)
      if ((r | (longint'(1) << b)) * (r | (longint'(1) << b)) <= v) r |= longint'(1) << b;
    return r;
  endfunction

  function automatic res_t shade(input req_t q);
    longint iv[3], nv[3], o[3];
    longint d, s, eta, d2, t, e2, p, k, r, m, one;
    logic f, tir;
    res_t y;
    f = 1'b0;
    tir = 1'b0;
    iv = '{longint'(q.inc_x), longint'(q.inc_y), longint'(q.inc_z)};
    nv = '{longint'(q.nrm_x), longint'(q.nrm_y), longint'(q.nrm_z)};
    eta = longint'(q.ratio);
    d = sat_to(rmul(iv[0], nv[0]) + rmul(iv[1], nv[1]) + rmul(iv[2], nv[2]), IW, f);
    if (q.action == ACT_REFLECT) begin
      s = sat_to(d * 2, IW, f);
      for (int i = 0; i < 3; i++) o[i] = sat_to(iv[i] - rmul(s, nv[i]), CW, f);
    end else begin
      one = longint'(1) << FB;
      d2 = sat_to(rmul(d, d), IW, f);
      t = sat_to(one - d2, IW, f);
      e2 = sat_to(rmul(eta, eta), IW, f);
      p = sat_to(rmul(e2, t), IW, f);
      k = sat_to(one - p, IW, f);
      if (k < 0) begin
        tir = 1'b1;
        o = '{0, 0, 0};
      end else begin
        r = int_sqrt(k << FB);
        m = sat_to(rmul(eta, d) + r, IW, f);
        for (int i = 0; i < 3; i++) o[i] = sat_to(rmul(eta, iv[i]) - rmul(m, nv[i]), CW, f);
      end
    end
    y.out_x = o[0][CW-1:0];
    y.out_y = o[1][CW-1:0];
    y.out_z = o[2][CW-1:0];
    y.total_internal = tir;
    y.saturated = f;
    return y;
  endfunction

  function automatic logic [CW-1:0] rnd_comp();
    case ($urandom_range(0, 5))
      0: return 16'h7fff;
      1: return 16'h8000;
      2, 3: return 16'($signed($urandom_range(0, 16384)) - 8192);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic req_t rnd_req();
    req_t q;
    q.action = action_e'($urandom_range(0, 1));
    q.inc_x = rnd_comp(); q.inc_y = rnd_comp(); q.inc_z = rnd_comp();
    q.nrm_x = rnd_comp(); q.nrm_y = rnd_comp(); q.nrm_z = rnd_comp();
    q.ratio = $urandom_range(0, 3) == 0 ? 15'($urandom) : 15'($urandom_range(4096, 12288));
    return q;
  endfunction

  function automatic req_t mk(input action_e a, input int ix, iy, iz, nx, ny, nz, input int e);
    req_t q;
    q.action = a;
    q.inc_x = ix[CW-1:0]; q.inc_y = iy[CW-1:0]; q.inc_z = iz[CW-1:0];
    q.nrm_x = nx[CW-1:0]; q.nrm_y = ny[CW-1:0]; q.nrm_z = nz[CW-1:0];
    q.ratio = e[CW-2:0];
    return q;
  endfunction

  task automatic add_row(input req_t q, input logic kn, input res_t r);
    row_t w;
    w.req = q; w.known = kn; w.res = r;
    rows.push_back(w);
  endtask

  task automatic send(input req_t q, input res_t e, input logic gaps);
    int g;
    if (gaps && $urandom_range(0, 3) == 0) begin
      start_i <= 1'b0;
      g = $urandom_range(1, 4);
      repeat (g) @(posedge clk_i);
    end
    start_i <= 1'b1;
    req_i <= q;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    expq.push_back(e);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (expq.size() == 0) begin
        $display("%0t unexpected result %p", $time, res_o);
        errors++;
      end else begin
        res_t e;
        e = expq.pop_front();
        if (res_o.out_x !== e.out_x || res_o.out_y !== e.out_y || res_o.out_z !== e.out_z ||
            res_o.total_internal !== e.total_internal || res_o.saturated !== e.saturated) begin
          $display("%0t mismatch expected %p actual %p", $time, e, res_o);
          errors++;
        end
      end
    end
  end

  initial begin
    #200000;
    $display("FAILURE");
    $finish;
  end

  initial begin
    int wait_cnt;
    add_row(mk(ACT_REFLECT, 0, 0, 0, 0, 0, 0, 0), 1'b1, '0);
    add_row(mk(ACT_REFLECT, 8192, 0, 0, 0, 0, 0, 32767), 1'b1, res_t'({16'sd8192, 16'sd0, 16'sd0, 2'b00}));
    add_row(mk(ACT_REFLECT, 0, -8192, 0, 0, 8192, 0, 0), 1'b1, res_t'({16'sd0, 16'sd8192, 16'sd0, 2'b00}));
    add_row(mk(ACT_REFRACT, 0, -8192, 0, 0, 8192, 0, 8192), 1'b0, '0);
    add_row(mk(ACT_REFRACT, 5793, -5793, 0, 0, 8192, 0, 12288), 1'b0, '0);
    add_row(mk(ACT_REFRACT, 8192, 0, 0, 0, 8192, 0, 24576), 1'b1, res_t'({16'sd0, 16'sd0, 16'sd0, 2'b10}));
    add_row(mk(ACT_REFRACT, 0, 0, 0, 0, 0, 0, 0), 1'b0, '0);
    add_row(mk(ACT_REFRACT, 0, 0, 0, 0, 0, 0, 32767), 1'b0, '0);
    add_row(mk(ACT_REFLECT, 32767, 32767, 32767, 32767, 32767, 32767, 0), 1'b0, '0);
    add_row(mk(ACT_REFLECT, -32768, -32768, -32768, -32768, -32768, -32768, 0), 1'b0, '0);
    add_row(mk(ACT_REFRACT, -32768, -32768, -32768, 32767, 32767, 32767, 32767), 1'b0, '0);
    add_row(mk(ACT_REFRACT, 32767, -32768, 32767, -32768, 32767, -32768, 1), 1'b0, '0);
    add_row(mk(ACT_REFLECT, 1, -1, 1, -1, 1, -1, 21845), 1'b0, '0);
    add_row(mk(ACT_REFRACT, 4096, -4096, 0, 8192, 0, 0, 10922), 1'b0, '0);

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (rows[i]) send(rows[i].req, rows[i].known ? rows[i].res : shade(rows[i].req), 1'b1);
    for (int n = 0; n < NRAND; n++) begin
      req_t q;
      q = rnd_req();
      send(q, shade(q), n < NRAND - 100);
    end
    start_i <= 1'b0;
    wait_cnt = 0;
    while (expq.size() != 0 && wait_cnt < 1000) begin
      @(posedge clk_i);
      wait_cnt++;
    end
    repeat (TAIL) @(posedge clk_i);
    if (errors == 0 && expq.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule
